### rtl/pm_frame_parser_classifier_core_assert.svh
// Assertion macros shared by the checker of the frame parser core.
`ifndef PM_FRAME_PARSER_CLASSIFIER_CORE_ASSERT_SVH
`define PM_FRAME_PARSER_CLASSIFIER_CORE_ASSERT_SVH

// Same-cycle implication, quiet while reset is asserted.
`define PFPC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet while reset is asserted.
`define PFPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Implication that is also checked across reset.
`define PFPC_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/pm_fpc_pkg.sv
// ----------------------------------------------------------------------------
// pm_fpc_pkg
// Shared types and constants of the frame parser and classifier core.
// ----------------------------------------------------------------------------
`default_nettype none

package pm_fpc_pkg;

  localparam logic [7:0]  HEADER_BYTE        = 8'h16;
  localparam logic [31:0] GOOD_LIMIT_RST     = 32'd100;
  localparam logic [31:0] MODERATE_LIMIT_RST = 32'd300;
  localparam int unsigned QUEUE_DEPTH_DEF    = 4;

  // Frame positions of the first byte of each big-endian value
  localparam logic [8:0]  POS_PM25           = 9'd11;
  localparam logic [8:0]  POS_PM10           = 9'd15;

  localparam int unsigned CFG_IDX_W          = 1;
  localparam int unsigned CFG_DATA_W         = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_GOOD_LIMIT     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODERATE_LIMIT = 1'd1;

  typedef enum logic [1:0] {
    LVL_GOOD     = 2'd0,
    LVL_MODERATE = 2'd1,
    LVL_HEAVY    = 2'd2
  } air_level_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_LENGTH  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_CHECK   = 2'd3
  } parse_phase_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       first_byte;
  } in_item_t;

  typedef struct packed {
    logic        checksum_ok;
    logic [31:0] pm25_value;
    logic [31:0] pm10_value;
    logic [1:0]  air_level;
  } out_item_t;

  // Finished frame waiting for classification
  typedef struct packed {
    logic        checksum_ok;
    logic [31:0] pm25_value;
    logic [31:0] pm10_value;
  } frame_rec_t;

endpackage

`default_nettype wire

### rtl/pm_frame_parser_classifier_core.sv
// ----------------------------------------------------------------------------
// pm_frame_parser_classifier_core
// Sum-complement checksummed sensor frame parser with PM2.5 level grading.
// ----------------------------------------------------------------------------
//
//   Port group   Direction  Handshake          Payload
//   in_          receive    in_valid/in_stall  in_item_t  (rx_byte, first_byte)
//   out_         send       out_valid/out_stall out_item_t (status, values, level)
//   cfg_         receive    cfg_we             cfg_index, cfg_data (32 bit)
//
// One byte transfer per cycle while in_stall is low; a frame with length byte L holds L + 3 bytes.
// A result is offered on out_ once the checksum byte is taken: the record
// queue is written first, then the result register loads unless a stalled
// result holds it. in_stall is high exactly while QUEUE_DEPTH finished
// records wait in the queue. Reset (rst_n low, synchronous) idles the
// parser, empties the queue and restores the limits to 100 and 300.
// ----------------------------------------------------------------------------
`default_nettype none

module pm_frame_parser_classifier_core
  import pm_fpc_pkg::*;
#(
  // Finished frames that may wait between parser and classifier
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Received byte stream
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  // Frame results
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data,
  // Limit registers
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // Records pass from the parser to the classifier through the queue
  logic       push;
  frame_rec_t push_rec;
  logic       q_full;
  logic       q_valid;
  frame_rec_t q_rec;
  logic       pop;

  // Front: follow header, length, payload and checksum byte by byte;
  // keep the running sum and capture the two big-endian values.
  pm_fpc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .q_full   (q_full),
    .push     (push),
    .push_rec (push_rec)
  );

  // Queue: decouple parsing from result delivery
  pm_fpc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .full     (q_full),
    .q_valid  (q_valid),
    .q_rec    (q_rec),
    .pop      (pop)
  );

  // Back: grade PM2.5 against the limits and hold the result until the
  // transfer completes; a new record is drawn as the old one leaves.
  pm_fpc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_rec     (q_rec),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### rtl/pm_fpc_front.sv
// ----------------------------------------------------------------------------
// pm_fpc_front
// Byte parser: tracks the frame, sums bytes, captures values, emits records.
// ----------------------------------------------------------------------------
`default_nettype none

module pm_fpc_front
  import pm_fpc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire in_item_t   in_data,
  output logic            in_stall,
  input  wire logic       q_full,
  output logic            push,
  output frame_rec_t      push_rec
);

  parse_phase_t phase_r, phase_nxt;
  logic [8:0]   pos_r, pos_nxt;
  logic [7:0]   len_r, len_nxt;
  logic [7:0]   sum_r, sum_nxt;
  logic [31:0]  pm25_r, pm25_nxt;
  logic [31:0]  pm10_r, pm10_nxt;

  logic         acc;
  logic [8:0]   pos_inc;
  logic [8:0]   off25, off10;
  logic [31:0]  cap25, cap10;
  logic [7:0]   rx;

  assign in_stall = q_full;
  assign acc      = in_valid & ~q_full;
  assign rx       = in_data.rx_byte;
  assign pos_inc  = pos_r + 9'd1;
  assign off25    = pos_r - POS_PM25;
  assign off10    = pos_r - POS_PM10;

  // Captures with the current byte placed, if it falls in a value field
  always_comb begin
    cap25 = pm25_r;
    cap10 = pm10_r;
    if (pos_r >= POS_PM25 && pos_r < POS_PM25 + 9'd4) begin
      cap25[(2'd3 - off25[1:0]) * 8 +: 8] = rx;
    end else if (pos_r >= POS_PM10 && pos_r < POS_PM10 + 9'd4) begin
      cap10[(2'd3 - off10[1:0]) * 8 +: 8] = rx;
    end
  end

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (acc) begin
      if (in_data.first_byte) begin
        phase_nxt = (rx == HEADER_BYTE) ? PH_LENGTH : PH_IDLE;
      end else begin
        case (phase_r)
          PH_IDLE:    phase_nxt = PH_IDLE;
          PH_LENGTH:  phase_nxt = (rx == 8'd0) ? PH_CHECK : PH_PAYLOAD;
          PH_PAYLOAD: begin
            if ({1'b0, pos_inc} >= {2'b00, len_r} + 10'd2) phase_nxt = PH_CHECK;
          end
          PH_CHECK:   phase_nxt = PH_IDLE;
          default:    phase_nxt = PH_IDLE;
        endcase
      end
    end
  end

  // Datapath and record output
  always_comb begin
    pos_nxt  = pos_r;
    len_nxt  = len_r;
    sum_nxt  = sum_r;
    pm25_nxt = pm25_r;
    pm10_nxt = pm10_r;
    push     = 1'b0;
    push_rec.checksum_ok = ((sum_r + rx) == 8'd0);
    push_rec.pm25_value  = cap25;
    push_rec.pm10_value  = cap10;
    if (acc) begin
      if (in_data.first_byte) begin
        if (rx == HEADER_BYTE) begin
          pos_nxt  = 9'd1;
          len_nxt  = 8'd0;
          sum_nxt  = HEADER_BYTE;
          pm25_nxt = '0;
          pm10_nxt = '0;
        end else begin
          pos_nxt = 9'd0;
        end
      end else begin
        case (phase_r)
          PH_IDLE: ;
          PH_LENGTH: begin
            len_nxt  = rx;
            sum_nxt  = sum_r + rx;
            pm25_nxt = cap25;
            pm10_nxt = cap10;
            pos_nxt  = 9'd2;
          end
          PH_PAYLOAD: begin
            sum_nxt  = sum_r + rx;
            pm25_nxt = cap25;
            pm10_nxt = cap10;
            pos_nxt  = pos_inc;
          end
          PH_CHECK: begin
            pm25_nxt = cap25;
            pm10_nxt = cap10;
            pos_nxt  = 9'd0;
            push     = 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pos_r   <= 9'd0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r  <= len_nxt;
    sum_r  <= sum_nxt;
    pm25_r <= pm25_nxt;
    pm10_r <= pm10_nxt;
  end

endmodule

`default_nettype wire

### rtl/pm_fpc_queue.sv
// ----------------------------------------------------------------------------
// pm_fpc_queue
// Short first-in first-out queue of finished frame records.
// ----------------------------------------------------------------------------
`default_nettype none

module pm_fpc_queue
  import pm_fpc_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire frame_rec_t push_rec,
  output logic            full,
  output logic            q_valid,
  output frame_rec_t      q_rec,
  input  wire logic       pop
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  frame_rec_t    mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == CW'(DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_rec   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

`default_nettype wire

### rtl/pm_fpc_back.sv
// ----------------------------------------------------------------------------
// pm_fpc_back
// Classifier: holds the limits, grades each record, drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pm_fpc_back
  import pm_fpc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  q_valid,
  input  wire frame_rec_t            q_rec,
  output logic                       pop,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data
);

  logic [31:0] good_lim_r, good_lim_nxt;
  logic [31:0] mod_lim_r, mod_lim_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r;
  air_level_t  level;

  assign pop       = q_valid & (~out_valid_r | ~out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    if (q_rec.pm25_value <= good_lim_r) begin
      level = LVL_GOOD;
    end else if (q_rec.pm25_value <= mod_lim_r) begin
      level = LVL_MODERATE;
    end else begin
      level = LVL_HEAVY;
    end
  end

  always_comb begin
    good_lim_nxt = good_lim_r;
    mod_lim_nxt  = mod_lim_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_GOOD_LIMIT:     good_lim_nxt = cfg_data;
        CFG_MODERATE_LIMIT: mod_lim_nxt  = cfg_data;
        default: ;
      endcase
    end
  end

  assign out_valid_nxt = pop | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      good_lim_r  <= GOOD_LIMIT_RST;
      mod_lim_r   <= MODERATE_LIMIT_RST;
      out_valid_r <= 1'b0;
    end else begin
      good_lim_r  <= good_lim_nxt;
      mod_lim_r   <= mod_lim_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r.checksum_ok <= q_rec.checksum_ok;
      out_data_r.pm25_value  <= q_rec.pm25_value;
      out_data_r.pm10_value  <= q_rec.pm10_value;
      out_data_r.air_level   <= level;
    end
  end

endmodule

`default_nettype wire

### rtl/pm_fpc_checker.sv
// ----------------------------------------------------------------------------
// pm_fpc_checker
// Port-level checks of the frame parser core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pm_frame_parser_classifier_core_assert.svh"

module pm_fpc_checker
  import pm_fpc_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_stall,
  input wire in_item_t              in_data,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire out_item_t             out_data,
  input wire logic                  cfg_we,
  input wire logic [CFG_IDX_W-1:0]  cfg_index,
  input wire logic [CFG_DATA_W-1:0] cfg_data
);

  // Shadow copies of the limits as written on the port
  logic [31:0] good_sh_r;
  logic [31:0] mod_sh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      good_sh_r <= GOOD_LIMIT_RST;
      mod_sh_r  <= MODERATE_LIMIT_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_GOOD_LIMIT) good_sh_r <= cfg_data;
      if (cfg_index == CFG_MODERATE_LIMIT) mod_sh_r <= cfg_data;
    end
  end

  `PFPC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result changed while stalled")

  `PFPC_ASSERT_IMPL(a_good_grade, out_valid && $stable(good_sh_r), (out_data.air_level == LVL_GOOD) == (out_data.pm25_value <= good_sh_r), "good grade disagrees with limit")

  `PFPC_ASSERT_IMPL(a_heavy_grade, out_valid && $stable(good_sh_r) && $stable(mod_sh_r) && out_data.pm25_value > good_sh_r && out_data.pm25_value > mod_sh_r, out_data.air_level == LVL_HEAVY, "value above both limits not graded heavy")

  `PFPC_ASSERT_ALWAYS(a_reset_quiet, $past(!rst_n), !out_valid && !in_stall, "not quiet after reset")

  // Input side is watched only for reset behaviour
  logic unused_in;
  assign unused_in = in_valid ^ (^in_data);

endmodule

bind pm_frame_parser_classifier_core pm_fpc_checker u_pm_fpc_checker (.*);

`default_nettype wire
